[design/assert_macros.svh]
// Assertion macros used by the translator design file.
// Each macro takes a label, a clock, an active-low reset, the property (for the NEVER form, a condition) and a message.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define VPM_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define VPM_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define VPM_ASSERT(lbl, clk, rstn, prop, msg)
`define VPM_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

[design/vpm_pkg.sv]
`timescale 1ns / 1ps
package vpm_pkg;

  localparam int unsigned RPAGE_W  = 17;
  localparam int unsigned VPAGE_W  = 17;
  localparam int unsigned OFFSET_W = 8;
  localparam int unsigned FLAGS_W  = 3;
  localparam int unsigned ADDR_W   = 25;
  localparam int unsigned CNT_W    = 18;
  localparam int unsigned ENTRY_W  = 20;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [FLAGS_W-1:0] FLAG_REF     = 3'b001;
  localparam logic [FLAGS_W-1:0] FLAG_DIRTY   = 3'b010;
  localparam logic [FLAGS_W-1:0] FLAG_PROTECT = 3'b100;
  localparam logic [FLAGS_W-1:0] FLAGS_VACANT = 3'd6;

  localparam logic [CFG_IDX_W-1:0] CFG_VPAGE_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RPAGE_COUNT = 1'b1;

  localparam logic [CNT_W-1:0] VPAGE_COUNT_RESET = 18'd16384;
  localparam logic [CNT_W-1:0] RPAGE_COUNT_RESET = 18'd16384;

  typedef enum logic [2:0] {
    OP_FETCH     = 3'd0,
    OP_STORE     = 3'd1,
    OP_PEEK      = 3'd2,
    OP_READ_MAP  = 3'd3,
    OP_WRITE_MAP = 3'd4,
    OP_SET_REF   = 3'd5,
    OP_SET_DIRTY = 3'd6,
    OP_NONE      = 3'd7
  } op_e;

  typedef enum logic [2:0] {
    FAULT_NONE        = 3'd0,
    FAULT_PAGE        = 3'd1,
    FAULT_PROTECT     = 3'd2,
    FAULT_VPAGE_RANGE = 3'd3,
    FAULT_RPAGE_RANGE = 3'd4,
    FAULT_PEEK_VACANT = 3'd5
  } fault_e;

  typedef struct packed {
    op_e                 op;
    logic [VPAGE_W-1:0]  vpage;
    logic [OFFSET_W-1:0] offset;
    logic [FLAGS_W-1:0]  new_flags;
    logic [RPAGE_W-1:0]  new_rpage;
    logic                vpage_bad;
    logic                rpage_bad;
  } req_t;

  typedef struct packed {
    logic [RPAGE_W-1:0] real_page;
    logic [ADDR_W-1:0]  real_address;
    logic [FLAGS_W-1:0] flags;
    fault_e             fault;
    logic [ADDR_W-1:0]  fault_address;
  } res_t;

  typedef struct packed {
    logic               en;
    logic [ENTRY_W-1:0] data;
  } wr_t;

endpackage

[design/vpm_map_mem.sv]
`timescale 1ns / 1ps
module vpm_map_mem #(
  parameter int unsigned DEPTH = 16384,
  parameter int unsigned AW    = 14
) (
  input  logic                        clk_i,
  input  logic                        rd_en_i,
  input  logic [AW-1:0]               rd_addr_i,
  output logic [vpm_pkg::ENTRY_W-1:0] rd_data_o,
  input  logic                        wr_en_i,
  input  logic [AW-1:0]               wr_addr_i,
  input  logic [vpm_pkg::ENTRY_W-1:0] wr_data_i
);

  logic [vpm_pkg::ENTRY_W-1:0] mem_q [DEPTH];
  logic [vpm_pkg::ENTRY_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[design/vpm_exec.sv]
`timescale 1ns / 1ps
module vpm_exec (
  input  vpm_pkg::req_t               req_i,
  input  logic [vpm_pkg::ENTRY_W-1:0] entry_i,
  output vpm_pkg::res_t               res_o,
  output vpm_pkg::wr_t                wr_o
);

  logic [vpm_pkg::FLAGS_W-1:0]  fl;
  logic [vpm_pkg::RPAGE_W-1:0]  rp;
  logic                         vacant;
  logic [vpm_pkg::ADDR_W-1:0]   fa;
  logic [vpm_pkg::FLAGS_W-1:0]  nfl;
  logic [vpm_pkg::RPAGE_W-1:0]  nrp;

  assign fl     = entry_i[vpm_pkg::FLAGS_W-1:0];
  assign rp     = entry_i[vpm_pkg::ENTRY_W-1:vpm_pkg::FLAGS_W];
  assign vacant = (fl == vpm_pkg::FLAGS_VACANT);
  assign fa     = {req_i.vpage, {vpm_pkg::OFFSET_W{1'b0}}};

  always_comb begin
    res_o   = '0;
    wr_o.en = 1'b0;
    nfl     = fl;
    nrp     = rp;
    if (req_i.op == vpm_pkg::OP_NONE) begin
      res_o = '0;
    end else if (req_i.vpage_bad) begin
      res_o.fault = vpm_pkg::FAULT_VPAGE_RANGE;
    end else begin
      case (req_i.op)
        vpm_pkg::OP_FETCH, vpm_pkg::OP_STORE: begin
          if (vacant) begin
            res_o.flags         = fl;
            res_o.fault         = vpm_pkg::FAULT_PAGE;
            res_o.fault_address = fa;
          end else if (req_i.op == vpm_pkg::OP_STORE && (fl & vpm_pkg::FLAG_PROTECT) != '0)
          begin
            res_o.flags         = fl;
            res_o.fault         = vpm_pkg::FAULT_PROTECT;
            res_o.fault_address = fa;
          end else begin
            nfl = (req_i.op == vpm_pkg::OP_STORE) ?
                  (fl | vpm_pkg::FLAG_REF | vpm_pkg::FLAG_DIRTY) : (fl | vpm_pkg::FLAG_REF);
            wr_o.en            = 1'b1;
            res_o.real_page    = rp;
            res_o.real_address = {rp, {vpm_pkg::OFFSET_W{1'b0}}};
            res_o.flags        = nfl;
          end
        end
        vpm_pkg::OP_PEEK: begin
          res_o.flags = fl;
          if (vacant) begin
            res_o.fault = vpm_pkg::FAULT_PEEK_VACANT;
          end else begin
            res_o.real_page    = rp;
            res_o.real_address = {rp, req_i.offset};
          end
        end
        vpm_pkg::OP_READ_MAP: begin
          res_o.flags = fl;
          if (!vacant) begin
            res_o.real_page    = rp;
            res_o.real_address = {rp, {vpm_pkg::OFFSET_W{1'b0}}};
          end
        end
        vpm_pkg::OP_WRITE_MAP: begin
          if (req_i.rpage_bad) begin
            res_o.fault = vpm_pkg::FAULT_RPAGE_RANGE;
          end else begin
            // A vacant entry always carries real page zero.
            nfl = req_i.new_flags;
            nrp = (req_i.new_flags == vpm_pkg::FLAGS_VACANT) ? '0 : req_i.new_rpage;
            wr_o.en            = 1'b1;
            res_o.real_page    = nrp;
            res_o.real_address = {nrp, {vpm_pkg::OFFSET_W{1'b0}}};
            res_o.flags        = nfl;
          end
        end
        vpm_pkg::OP_SET_REF, vpm_pkg::OP_SET_DIRTY: begin
          nfl = (req_i.op == vpm_pkg::OP_SET_DIRTY) ?
                (fl | vpm_pkg::FLAG_REF | vpm_pkg::FLAG_DIRTY) : (fl | vpm_pkg::FLAG_REF);
          wr_o.en            = 1'b1;
          res_o.real_page    = rp;
          res_o.real_address = {rp, {vpm_pkg::OFFSET_W{1'b0}}};
          res_o.flags        = nfl;
        end
        default: begin
          res_o = '0;
        end
      endcase
    end
    wr_o.data = {nrp, nfl};
  end

endmodule

[design/virtual_page_map_translator.sv]
`timescale 1ns / 1ps
// Virtual page map translator.
// Commands enter on start_i with op_i, vpage_i, offset_i, new_flags_i and new_rpage_i;
// a command word is taken at a clock edge where start_i is high and busy_o is low.
// Each command gives exactly one result word on real_page_o, real_address_o, flags_o,
// fault_o and fault_address_o, marked by result_valid_o for a single cycle. The receiver
// has no way to stall, so each result must be captured in the cycle it is shown.
// A command word and its map read are registered at the edge that takes it; the result
// word is registered at the edge that ends busy_o, and no new command is taken before.
// The map sits in a single-port-read, single-port-write memory with a registered read;
// busy_o covers the cycle in which the entry is read back, modified and written, so
// successive commands never touch the map at overlapping times.
// The page and real-page counts are written through cfg_valid_i/cfg_index_i/cfg_data_i,
// which is always ready, and should only be written while the block is idle.
// Reset sets both counts to 16384 and drops any command in flight. Map entries are not
// cleared by reset and must be written before they are used.
module virtual_page_map_translator #(
  parameter int unsigned MAX_VPAGES = 16384
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [2:0]                    op_i,
  input  logic [vpm_pkg::VPAGE_W-1:0]   vpage_i,
  input  logic [vpm_pkg::OFFSET_W-1:0]  offset_i,
  input  logic [vpm_pkg::FLAGS_W-1:0]   new_flags_i,
  input  logic [vpm_pkg::RPAGE_W-1:0]   new_rpage_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [vpm_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [vpm_pkg::CNT_W-1:0]     cfg_data_i,
  output logic                          result_valid_o,
  output logic [vpm_pkg::RPAGE_W-1:0]   real_page_o,
  output logic [vpm_pkg::ADDR_W-1:0]    real_address_o,
  output logic [vpm_pkg::FLAGS_W-1:0]   flags_o,
  output logic [2:0]                    fault_o,
  output logic [vpm_pkg::ADDR_W-1:0]    fault_address_o
);

`include "assert_macros.svh"

  localparam int unsigned AW = $clog2(MAX_VPAGES);
  localparam logic [vpm_pkg::CNT_W-1:0] MaxVpagesCnt = vpm_pkg::CNT_W'(MAX_VPAGES);

  logic [vpm_pkg::CNT_W-1:0]   vpage_count_q;
  logic [vpm_pkg::CNT_W-1:0]   rpage_count_q;
  logic                        accept;
  logic                        s1_valid_q, s1_valid_d;
  vpm_pkg::req_t               req_d, req_q;
  logic [vpm_pkg::ENTRY_W-1:0] entry;
  vpm_pkg::res_t               res;
  vpm_pkg::wr_t                wr;
  logic                        mem_we;
  logic                        result_valid_q;
  vpm_pkg::res_t               res_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vpage_count_q <= vpm_pkg::VPAGE_COUNT_RESET;
      rpage_count_q <= vpm_pkg::RPAGE_COUNT_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        vpm_pkg::CFG_VPAGE_COUNT: vpage_count_q <= cfg_data_i;
        vpm_pkg::CFG_RPAGE_COUNT: rpage_count_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign accept = start_i && !busy_o;
  assign busy_o = s1_valid_q;

  always_comb begin
    req_d.op        = vpm_pkg::op_e'(op_i);
    req_d.vpage     = vpage_i;
    req_d.offset    = offset_i;
    req_d.new_flags = new_flags_i;
    req_d.new_rpage = new_rpage_i;
    req_d.vpage_bad = ({1'b0, vpage_i} >= vpage_count_q) || ({1'b0, vpage_i} >= MaxVpagesCnt);
    req_d.rpage_bad = ({1'b0, new_rpage_i} >= rpage_count_q);
    s1_valid_d      = accept;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_d;
    end
  end

  // Out-of-range pages never write, so the truncated address is always inside the map.
  assign mem_we = s1_valid_q && wr.en;

  vpm_map_mem #(
    .DEPTH (MAX_VPAGES),
    .AW    (AW)
  ) u_map_mem (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .rd_addr_i (vpage_i[AW-1:0]),
    .rd_data_o (entry),
    .wr_en_i   (mem_we),
    .wr_addr_i (req_q.vpage[AW-1:0]),
    .wr_data_i (wr.data)
  );

  vpm_exec u_exec (
    .req_i   (req_q),
    .entry_i (entry),
    .res_o   (res),
    .wr_o    (wr)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_q <= 1'b0;
    end else begin
      result_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      res_q <= res;
    end
  end

  assign result_valid_o  = result_valid_q;
  assign real_page_o     = res_q.real_page;
  assign real_address_o  = res_q.real_address;
  assign flags_o         = res_q.flags;
  assign fault_o         = res_q.fault;
  assign fault_address_o = res_q.fault_address;

  `VPM_ASSERT(a_accept_busy, clk_i, rst_ni, accept |=> busy_o, "accepted word did not raise busy")
  `VPM_ASSERT(a_one_result, clk_i, rst_ni, s1_valid_q |=> result_valid_o, "result word missing")
  `VPM_ASSERT_NEVER(a_result_while_busy, clk_i, rst_ni,
    result_valid_o && busy_o, "result overlaps busy")
  `VPM_ASSERT_NEVER(a_stray_write, clk_i, rst_ni,
    mem_we && req_q.vpage_bad, "map written out of range")
  `VPM_ASSERT(a_fault_zero_page, clk_i, rst_ni,
    (result_valid_o && fault_o != vpm_pkg::FAULT_NONE) |-> (real_page_o == '0), "faulting word has page")

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;

  localparam int unsigned MAP_PAGES       = 16384;
  localparam int unsigned VPAGE_MAX       = 2**vpm_pkg::VPAGE_W - 1;
  localparam int unsigned RAND_PHASES     = 5;
  localparam int unsigned ITEMS_PER_PHASE = 200;

  // Mirror of the page map and the two counts, with the words still owed by the block.
  class translation_checker;
    logic [vpm_pkg::ENTRY_W-1:0] page_map [MAP_PAGES];
    bit                          written [MAP_PAGES];
    logic [vpm_pkg::CNT_W-1:0]   vpage_count;
    logic [vpm_pkg::CNT_W-1:0]   rpage_count;
    vpm_pkg::res_t               expected_words [$];
    int unsigned                 fails;

    function new();
      vpage_count = vpm_pkg::VPAGE_COUNT_RESET;
      rpage_count = vpm_pkg::RPAGE_COUNT_RESET;
      fails = 0;
    endfunction

    function void set_count(logic [vpm_pkg::CFG_IDX_W-1:0] idx,
                            logic [vpm_pkg::CNT_W-1:0] value);
      if (idx == vpm_pkg::CFG_VPAGE_COUNT) begin
        vpage_count = value;
      end else begin
        rpage_count = value;
      end
    endfunction

    function bit in_range(logic [vpm_pkg::VPAGE_W-1:0] vp);
      return (vp < vpage_count) && (vp < MAP_PAGES);
    endfunction

    function void predict_translation(vpm_pkg::op_e op, logic [vpm_pkg::VPAGE_W-1:0] vp,
                                      logic [vpm_pkg::OFFSET_W-1:0] ofs,
                                      logic [vpm_pkg::FLAGS_W-1:0] nf,
                                      logic [vpm_pkg::RPAGE_W-1:0] nr);
      vpm_pkg::res_t               r;
      logic [vpm_pkg::FLAGS_W-1:0] fl;
      logic [vpm_pkg::RPAGE_W-1:0] rp;
      logic [vpm_pkg::ADDR_W-1:0]  fa;
      r = '0;
      r.fault = vpm_pkg::FAULT_NONE;
      if (op != vpm_pkg::OP_NONE && !in_range(vp)) begin
        r.fault = vpm_pkg::FAULT_VPAGE_RANGE;
      end else if (op != vpm_pkg::OP_NONE) begin
        fl = page_map[vp][vpm_pkg::FLAGS_W-1:0];
        rp = page_map[vp][vpm_pkg::ENTRY_W-1:vpm_pkg::FLAGS_W];
        fa = {vp, 8'h00};
        r.flags = fl;
        case (op)
          vpm_pkg::OP_FETCH, vpm_pkg::OP_STORE: begin
            if (fl == vpm_pkg::FLAGS_VACANT) begin
              r.fault = vpm_pkg::FAULT_PAGE;
              r.fault_address = fa;
            end else if (op == vpm_pkg::OP_STORE && (fl & vpm_pkg::FLAG_PROTECT) != '0) begin
              r.fault = vpm_pkg::FAULT_PROTECT;
              r.fault_address = fa;
            end else begin
              fl = fl | ((op == vpm_pkg::OP_STORE) ?
                         (vpm_pkg::FLAG_REF | vpm_pkg::FLAG_DIRTY) : vpm_pkg::FLAG_REF);
              page_map[vp] = {rp, fl};
              r.real_page = rp;
              r.real_address = {rp, 8'h00};
              r.flags = fl;
            end
          end
          vpm_pkg::OP_PEEK: begin
            if (fl == vpm_pkg::FLAGS_VACANT) begin
              r.fault = vpm_pkg::FAULT_PEEK_VACANT;
            end else begin
              r.real_page = rp;
              r.real_address = {rp, ofs};
            end
          end
          vpm_pkg::OP_READ_MAP: begin
            if (fl == vpm_pkg::FLAGS_VACANT) begin
              rp = '0;
            end
            r.real_page = rp;
            r.real_address = {rp, 8'h00};
          end
          vpm_pkg::OP_WRITE_MAP: begin
            // The real-page check comes before a vacant entry's page is forced to zero.
            if (nr >= rpage_count) begin
              r = '0;
              r.fault = vpm_pkg::FAULT_RPAGE_RANGE;
            end else begin
              if (nf == vpm_pkg::FLAGS_VACANT) begin
                nr = '0;
              end
              page_map[vp] = {nr, nf};
              written[vp] = 1'b1;
              r.real_page = nr;
              r.real_address = {nr, 8'h00};
              r.flags = nf;
            end
          end
          default: begin
            fl = fl | ((op == vpm_pkg::OP_SET_DIRTY) ?
                       (vpm_pkg::FLAG_REF | vpm_pkg::FLAG_DIRTY) : vpm_pkg::FLAG_REF);
            page_map[vp] = {rp, fl};
            r.real_page = rp;
            r.real_address = {rp, 8'h00};
            r.flags = fl;
          end
        endcase
      end
      expected_words.push_back(r);
    endfunction

    function void compare_field(string name, logic [vpm_pkg::ADDR_W-1:0] want,
                                logic [vpm_pkg::ADDR_W-1:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        fails++;
      end
    endfunction

    function void check_translation(vpm_pkg::res_t got);
      vpm_pkg::res_t want;
      if (expected_words.size() == 0) begin
        $error("result word arrived with no command outstanding");
        fails++;
        return;
      end
      want = expected_words.pop_front();
      compare_field("real_page", want.real_page, got.real_page);
      compare_field("real_address", want.real_address, got.real_address);
      compare_field("flags", want.flags, got.flags);
      compare_field("fault", want.fault, got.fault);
      compare_field("fault_address", want.fault_address, got.fault_address);
    endfunction
  endclass

  logic                          clk_i;
  logic                          rst_ni;
  logic                          start_i;
  logic                          busy_o;
  logic [2:0]                    op_i;
  logic [vpm_pkg::VPAGE_W-1:0]   vpage_i;
  logic [vpm_pkg::OFFSET_W-1:0]  offset_i;
  logic [vpm_pkg::FLAGS_W-1:0]   new_flags_i;
  logic [vpm_pkg::RPAGE_W-1:0]   new_rpage_i;
  logic                          cfg_valid_i;
  logic                          cfg_ready_o;
  logic [vpm_pkg::CFG_IDX_W-1:0] cfg_index_i;
  logic [vpm_pkg::CNT_W-1:0]     cfg_data_i;
  logic                          result_valid_o;
  logic [vpm_pkg::RPAGE_W-1:0]   real_page_o;
  logic [vpm_pkg::ADDR_W-1:0]    real_address_o;
  logic [vpm_pkg::FLAGS_W-1:0]   flags_o;
  logic [2:0]                    fault_o;
  logic [vpm_pkg::ADDR_W-1:0]    fault_address_o;

  translation_checker          sb;
  bit                          no_idle;
  logic [vpm_pkg::VPAGE_W-1:0] page_pool [$];

  virtual_page_map_translator dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .op_i           (op_i),
    .vpage_i        (vpage_i),
    .offset_i       (offset_i),
    .new_flags_i    (new_flags_i),
    .new_rpage_i    (new_rpage_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .result_valid_o (result_valid_o),
    .real_page_o    (real_page_o),
    .real_address_o (real_address_o),
    .flags_o        (flags_o),
    .fault_o        (fault_o),
    .fault_address_o(fault_address_o)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // The receiver cannot stall, so every strobed word is checked at the edge that ends it.
  always @(posedge clk_i) begin
    vpm_pkg::res_t got;
    if (rst_ni === 1'b1 && result_valid_o === 1'b1) begin
      got.real_page = real_page_o;
      got.real_address = real_address_o;
      got.flags = flags_o;
      got.fault = vpm_pkg::fault_e'(fault_o);
      got.fault_address = fault_address_o;
      sb.check_translation(got);
    end
  end

  task automatic issue_command(vpm_pkg::op_e op, logic [vpm_pkg::VPAGE_W-1:0] vp,
                               logic [vpm_pkg::OFFSET_W-1:0] ofs,
                               logic [vpm_pkg::FLAGS_W-1:0] nf,
                               logic [vpm_pkg::RPAGE_W-1:0] nr);
    @(negedge clk_i);
    while (!no_idle && $urandom_range(0, 99) < 31) begin
      start_i = 1'b0;
      @(negedge clk_i);
    end
    start_i = 1'b1;
    op_i = op;
    vpage_i = vp;
    offset_i = ofs;
    new_flags_i = nf;
    new_rpage_i = nr;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    sb.predict_translation(op, vp, ofs, nf, nr);
  endtask

  task automatic write_count(logic [vpm_pkg::CFG_IDX_W-1:0] idx,
                             logic [vpm_pkg::CNT_W-1:0] value);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = value;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    sb.set_count(idx, value);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic drain();
    @(negedge clk_i);
    start_i = 1'b0;
    while (sb.expected_words.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // A small set of pages is reused so that entries are written, then read and modified.
  function automatic void build_pool();
    int unsigned lim;
    logic [31:0] rnd;
    lim = (sb.vpage_count < MAP_PAGES) ? sb.vpage_count : MAP_PAGES;
    lim = lim - 1;
    page_pool.delete();
    page_pool.push_back('0);
    page_pool.push_back(lim[vpm_pkg::VPAGE_W-1:0]);
    repeat (22) begin
      rnd = $urandom_range(0, lim);
      page_pool.push_back(rnd[vpm_pkg::VPAGE_W-1:0]);
    end
  endfunction

  task automatic random_command();
    vpm_pkg::op_e                op;
    logic [vpm_pkg::VPAGE_W-1:0] vp;
    logic [vpm_pkg::FLAGS_W-1:0] nf;
    logic [vpm_pkg::RPAGE_W-1:0] nr;
    logic [31:0]                 rnd;
    int unsigned                 pick;
    int unsigned                 lim;
    lim = (sb.vpage_count < MAP_PAGES) ? sb.vpage_count : MAP_PAGES;
    op = vpm_pkg::op_e'($urandom_range(0, 7));
    pick = $urandom_range(0, 99);
    if (pick < 85) begin
      vp = page_pool[$urandom_range(0, page_pool.size() - 1)];
    end else if (pick < 95) begin
      rnd = $urandom_range(lim, VPAGE_MAX);
      vp = rnd[vpm_pkg::VPAGE_W-1:0];
    end else begin
      rnd = $urandom_range(0, VPAGE_MAX);
      vp = rnd[vpm_pkg::VPAGE_W-1:0];
    end
    rnd = $urandom_range(0, 7);
    nf = ($urandom_range(0, 3) == 0) ? vpm_pkg::FLAGS_VACANT : rnd[vpm_pkg::FLAGS_W-1:0];
    if ($urandom_range(0, 6) == 0) begin
      rnd = $urandom_range(0, VPAGE_MAX);
    end else begin
      rnd = $urandom_range(0, sb.rpage_count - 1);
    end
    nr = rnd[vpm_pkg::RPAGE_W-1:0];
    // An entry that was never written must not be read, so the command on it becomes a map write.
    if (op != vpm_pkg::OP_NONE && op != vpm_pkg::OP_WRITE_MAP && sb.in_range(vp) &&
        !sb.written[vp]) begin
      op = vpm_pkg::OP_WRITE_MAP;
      rnd = $urandom_range(0, sb.rpage_count - 1);
      nr = rnd[vpm_pkg::RPAGE_W-1:0];
    end
    rnd = $urandom_range(0, 255);
    issue_command(op, vp, rnd[vpm_pkg::OFFSET_W-1:0], nf, nr);
  endtask

  initial begin
    logic [vpm_pkg::CNT_W-1:0] vcnt;
    logic [vpm_pkg::CNT_W-1:0] rcnt;
    logic [31:0]               rnd;
    rst_ni = 1'b0;
    start_i = 1'b0;
    op_i = '0;
    vpage_i = '0;
    offset_i = '0;
    new_flags_i = '0;
    new_rpage_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    no_idle = 1'b0;
    sb = new();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    issue_command(vpm_pkg::OP_WRITE_MAP, 17'd0, 8'd0, 3'd0, 17'd0);
    issue_command(vpm_pkg::OP_WRITE_MAP, 17'd16383, 8'd0, 3'd3, 17'd16383);
    issue_command(vpm_pkg::OP_WRITE_MAP, 17'd1, 8'd0, vpm_pkg::FLAGS_VACANT, 17'd5);
    issue_command(vpm_pkg::OP_WRITE_MAP, 17'd2, 8'd0, vpm_pkg::FLAG_PROTECT, 17'd100);
    issue_command(vpm_pkg::OP_WRITE_MAP, 17'd3, 8'd0, 3'd0, 17'd16384);
    issue_command(vpm_pkg::OP_WRITE_MAP, 17'd3, 8'd0, vpm_pkg::FLAGS_VACANT, 17'h1FFFF);
    issue_command(vpm_pkg::OP_FETCH, 17'd0, 8'd0, 3'd0, 17'd0);
    issue_command(vpm_pkg::OP_STORE, 17'd0, 8'd0, 3'd0, 17'd0);
    issue_command(vpm_pkg::OP_PEEK, 17'd0, 8'hFF, 3'd0, 17'd0);
    issue_command(vpm_pkg::OP_PEEK, 17'd16383, 8'h55, 3'd7, 17'h1FFFF);
    issue_command(vpm_pkg::OP_READ_MAP, 17'd1, 8'd0, 3'd0, 17'd0);
    issue_command(vpm_pkg::OP_FETCH, 17'd1, 8'd0, 3'd0, 17'd0);
    issue_command(vpm_pkg::OP_STORE, 17'd1, 8'd0, 3'd0, 17'd0);
    issue_command(vpm_pkg::OP_PEEK, 17'd1, 8'hAA, 3'd0, 17'd0);
    issue_command(vpm_pkg::OP_STORE, 17'd2, 8'd0, 3'd0, 17'd0);
    issue_command(vpm_pkg::OP_FETCH, 17'd2, 8'd0, 3'd0, 17'd0);
    issue_command(vpm_pkg::OP_SET_REF, 17'd1, 8'd0, 3'd0, 17'd0);
    issue_command(vpm_pkg::OP_READ_MAP, 17'd1, 8'd0, 3'd0, 17'd0);
    issue_command(vpm_pkg::OP_SET_DIRTY, 17'd2, 8'd0, 3'd0, 17'd0);
    issue_command(vpm_pkg::OP_FETCH, 17'd16384, 8'd0, 3'd0, 17'd0);
    issue_command(vpm_pkg::OP_WRITE_MAP, 17'h1FFFF, 8'hFF, 3'd7, 17'd1);
    issue_command(vpm_pkg::OP_STORE, 17'h1FFFF, 8'd0, 3'd0, 17'd0);
    issue_command(vpm_pkg::OP_NONE, 17'h1FFFF, 8'hFF, 3'd7, 17'h1FFFF);
    issue_command(vpm_pkg::OP_READ_MAP, 17'd16383, 8'd0, 3'd0, 17'd0);

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0: begin
          vcnt = 18'd4096;
          rcnt = 18'd1;
        end
        1: begin
          vcnt = 18'd131072;
          rcnt = 18'd131072;
        end
        3: begin
          vcnt = 18'd16384;
          rcnt = 18'd4096;
        end
        default: begin
          rnd = $urandom_range(4096, 131072);
          vcnt = rnd[vpm_pkg::CNT_W-1:0];
          rnd = $urandom_range(1, 131072);
          rcnt = rnd[vpm_pkg::CNT_W-1:0];
        end
      endcase
      drain();
      write_count(vpm_pkg::CFG_VPAGE_COUNT, vcnt);
      write_count(vpm_pkg::CFG_RPAGE_COUNT, rcnt);
      build_pool();
      no_idle = (ph == 1);
      repeat (ITEMS_PER_PHASE) random_command();
    end
    drain();

    if (sb.fails == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

[files.f]
+incdir+design
design/vpm_pkg.sv
design/vpm_map_mem.sv
design/vpm_exec.sv
design/virtual_page_map_translator.sv
sim/tb_top.sv
